[sv/wtra_pkg.sv]
// package: shared types, constants and digit helper of the true range average unit
package wtra_pkg;

	localparam int PRICE_BITS   = 32;
	localparam int WINDOW_BITS  = 9;
	localparam int DIGIT_BITS   = 8;
	localparam int PRICE_DIGITS = PRICE_BITS / DIGIT_BITS;
	localparam int RESET_WINDOW = 14;

	typedef logic [PRICE_BITS-1:0]  price_t;
	typedef logic [DIGIT_BITS-1:0]  digit_t;
	typedef logic [WINDOW_BITS-1:0] window_t;

	typedef struct packed {
		price_t bar_high;
		price_t bar_low;
		price_t bar_close;
	} bar_t;

	typedef struct packed {
		price_t range_average;
		logic   average_valid;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_PICK,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	// one digit of a - b - borrow in; the msb is the borrow out
	function automatic logic [DIGIT_BITS:0] sub_digit(digit_t a, digit_t b, logic bin);
		sub_digit = {1'b0, a} - {1'b0, b} - {{DIGIT_BITS{1'b0}}, bin};
	endfunction

endpackage

[sv/wtra_ram.sv]
// generic single write port ram with registered read
module wtra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[sv/windowed_true_range_average_unit.sv]
// top level: digit-serial windowed average of bar true ranges
//
// one request carries a price bar (high, low, close). from the second bar after
// reset or a window write on, the true range max(high - low, |high - prev close|,
// |low - prev close|) is formed, stored in a ring of MAX_WINDOW entries and
// kept in a running window sum; each request gives one result, the sum divided
// by the window length (truncated) once more than window-length bars were seen,
// else zero with average_valid low. the block works on one request at a time:
// the first bar of a history skips the serial passes, any other bar runs the
// byte-serial subtract, compare and sum-update passes, and a bar with a valid
// average also the radix-2 divider, which produces one quotient bit per cycle.
// a finished result sits in an output register, so a new request is taken while
// the result still waits.
// writing the window register clears the history; 0 acts as 1 and values
// above MAX_WINDOW act as MAX_WINDOW. write it only while the block is idle.
module windowed_true_range_average_unit #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     bar_valid,
	output logic                     bar_ready,
	input  wtra_pkg::bar_t           bar,
	output logic                     result_valid,
	input  logic                     result_ready,
	output wtra_pkg::result_t        result,
	input  logic                     cfg_we,
	input  wtra_pkg::window_t        cfg_wdata
);

	import wtra_pkg::*;

	// widths that follow from the ring depth
	localparam int LOG_W      = $clog2(MAX_WINDOW);
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int SEEN_W     = $clog2(MAX_WINDOW + 2);
	localparam int SUM_BITS   = PRICE_BITS + LOG_W;
	localparam int SUM_DIGITS = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int SUM_W      = SUM_DIGITS * DIGIT_BITS;
	localparam int CNT_W      = $clog2(PRICE_BITS);
	localparam int RESET_WIN  = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;
	localparam int D          = DIGIT_BITS;
	localparam int P          = PRICE_BITS;

	state_t state_q, state_d;

	// history and control
	logic [WIN_W-1:0]  win_q;      // clamped window length
	logic [SEEN_W-1:0] seen_q;     // bars seen, saturating
	logic [LOG_W-1:0]  pos_q;      // ring slot for the next true range
	logic [SUM_W-1:0]  sum_q;      // window sum, rotated a byte per step
	logic [P-1:0]      pc_q;       // previous close, then pc - high during the range pass
	logic [CNT_W-1:0]  cnt_q;
	logic              full_q;     // window already full: oldest range leaves
	logic              valid_q;    // this bar gives a valid average
	logic              result_valid_q;

	// datapath shift registers
	logic [P-1:0]      hi_q;       // high, then high - pc, then gap to high
	logic [P-1:0]      lo_q;       // low, then low - pc, then gap to low
	logic [P-1:0]      hl_q;       // high - low, then true range
	logic [P-1:0]      pl_q;       // pc - low, then the leaving ring entry
	logic [P-1:0]      close_q;
	logic [P-1:0]      quo_q;      // dividend low bits, shifting into the quotient
	logic [LOG_W-1:0]  rem_q;
	logic [4:0]        bor_q;      // borrows of the serial subtractors
	logic [1:0]        cy_q;       // signed carry of the sum update
	result_t           result_q;

	logic              accept;
	logic              step_last;
	logic [WIN_W-1:0]  win_wr;
	logic [SEEN_W-1:0] seen_inc;
	logic              ram_we;
	logic [P-1:0]      ram_rd;

	// range pass digits
	logic [D:0]        r_hl, r_hp, r_ph, r_lp, r_pl;
	logic [P-1:0]      hl_sh, hp_sh, ph_sh, lp_sh, pl_sh;

	// pick pass digits
	logic [D:0]        r_ab, r_ac, r_bc;
	logic [P-1:0]      a_rot, b_rot, c_rot, tr_pick;

	// sum pass
	logic [D+1:0]      sum_t;
	logic [SUM_W-1:0]  sum_nx;

	// divider step
	logic [LOG_W:0]    rem_sh;
	logic [LOG_W+1:0]  trial;
	logic              qbit;
	logic [LOG_W:0]    pos_inc;

	assign bar_ready    = (state_q == ST_IDLE);
	assign accept       = bar_valid && bar_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// clamp of a written window length
	always_comb begin
		if (cfg_wdata == '0) begin
			win_wr = WIN_W'(1);
		end else if (int'(cfg_wdata) > MAX_WINDOW) begin
			win_wr = WIN_W'(MAX_WINDOW);
		end else begin
			win_wr = WIN_W'(cfg_wdata);
		end
	end

	assign seen_inc = (seen_q == SEEN_W'(MAX_WINDOW + 1)) ? seen_q : seen_q + 1'b1;

	// byte-serial subtractors for the three gaps, lsb first
	always_comb begin
		r_hl  = sub_digit(hi_q[D-1:0], lo_q[D-1:0], bor_q[0]);
		r_hp  = sub_digit(hi_q[D-1:0], pc_q[D-1:0], bor_q[1]);
		r_ph  = sub_digit(pc_q[D-1:0], hi_q[D-1:0], bor_q[2]);
		r_lp  = sub_digit(lo_q[D-1:0], pc_q[D-1:0], bor_q[3]);
		r_pl  = sub_digit(pc_q[D-1:0], lo_q[D-1:0], bor_q[4]);
		hl_sh = {r_hl[D-1:0], hl_q[P-1:D]};
		hp_sh = {r_hp[D-1:0], hi_q[P-1:D]};
		ph_sh = {r_ph[D-1:0], pc_q[P-1:D]};
		lp_sh = {r_lp[D-1:0], lo_q[P-1:D]};
		pl_sh = {r_pl[D-1:0], pl_q[P-1:D]};
	end

	// serial three-way compare; operands rotate back into place
	always_comb begin
		r_ab  = sub_digit(hl_q[D-1:0], hi_q[D-1:0], bor_q[0]);
		r_ac  = sub_digit(hl_q[D-1:0], lo_q[D-1:0], bor_q[1]);
		r_bc  = sub_digit(hi_q[D-1:0], lo_q[D-1:0], bor_q[2]);
		a_rot = {hl_q[D-1:0], hl_q[P-1:D]};
		b_rot = {hi_q[D-1:0], hi_q[P-1:D]};
		c_rot = {lo_q[D-1:0], lo_q[P-1:D]};
		if (!r_ab[D] && !r_ac[D]) begin
			tr_pick = a_rot;
		end else if (r_ab[D] && !r_bc[D]) begin
			tr_pick = b_rot;
		end else begin
			tr_pick = c_rot;
		end
	end

	// sum + new range - leaving range, one byte per step
	always_comb begin
		sum_t  = {2'b00, sum_q[D-1:0]} + {2'b00, hl_q[D-1:0]} - {2'b00, pl_q[D-1:0]}
			+ {{D{cy_q[1]}}, cy_q};
		sum_nx = {sum_t[D-1:0], sum_q[SUM_W-1:D]};
	end

	// restoring divider step by the window length
	always_comb begin
		rem_sh = {rem_q, quo_q[P-1]};
		trial  = {1'b0, rem_sh} - (LOG_W + 2)'(win_q);
		qbit   = !trial[LOG_W+1];
	end

	assign pos_inc = {1'b0, pos_q} + 1'b1;

	// ring of true ranges
	wtra_ram #(
		.WIDTH (P),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (pos_q),
		.wr_data (tr_pick),
		.rd_addr (pos_q),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		step_last = 1'b0;
		ram_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (seen_q == '0) ? ST_DONE : ST_RANGE;
				end
			end
			ST_RANGE: begin
				step_last = (cnt_q == CNT_W'(PRICE_DIGITS - 1));
				if (step_last) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				step_last = (cnt_q == CNT_W'(PRICE_DIGITS - 1));
				if (step_last) begin
					ram_we  = 1'b1;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				step_last = (cnt_q == CNT_W'(SUM_DIGITS - 1));
				if (step_last) begin
					state_d = valid_q ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				step_last = (cnt_q == CNT_W'(P - 1));
				if (step_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// history, counters and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q          <= WIN_W'(RESET_WIN);
			seen_q         <= '0;
			pos_q          <= '0;
			sum_q          <= '0;
			pc_q           <= '0;
			cnt_q          <= '0;
			full_q         <= 1'b0;
			valid_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (state_q != ST_IDLE && state_q != ST_DONE) begin
				cnt_q <= step_last ? '0 : cnt_q + 1'b1;
			end
			if (cfg_we) begin
				// a window write starts a new history
				win_q  <= win_wr;
				seen_q <= '0;
				pos_q  <= '0;
				sum_q  <= '0;
				pc_q   <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (accept) begin
							full_q  <= (seen_q > SEEN_W'(win_q));
							valid_q <= (seen_inc > SEEN_W'(win_q));
							seen_q  <= seen_inc;
						end
					end
					ST_RANGE: begin
						pc_q <= ph_sh;
					end
					ST_PICK: begin
						if (step_last) begin
							pos_q <= (pos_inc >= (LOG_W + 1)'(win_q)) ? '0 : pos_inc[LOG_W-1:0];
						end
					end
					ST_SUM: begin
						sum_q <= sum_nx;
					end
					ST_DONE: begin
						pc_q <= close_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					hi_q    <= bar.bar_high;
					lo_q    <= bar.bar_low;
					close_q <= bar.bar_close;
					bor_q   <= '0;
				end
			end
			ST_RANGE: begin
				if (step_last) begin
					// high below low counts as zero; each gap takes the non-negative side
					hl_q  <= r_hl[D] ? '0 : hl_sh;
					hi_q  <= r_hp[D] ? ph_sh : hp_sh;
					lo_q  <= r_lp[D] ? pl_sh : lp_sh;
					bor_q <= '0;
				end else begin
					hl_q  <= hl_sh;
					hi_q  <= hp_sh;
					lo_q  <= lp_sh;
					pl_q  <= pl_sh;
					bor_q <= {r_pl[D], r_lp[D], r_ph[D], r_hp[D], r_hl[D]};
				end
			end
			ST_PICK: begin
				if (step_last) begin
					hl_q <= tr_pick;
					pl_q <= full_q ? ram_rd : '0;
					cy_q <= '0;
				end else begin
					hl_q  <= a_rot;
					hi_q  <= b_rot;
					lo_q  <= c_rot;
					bor_q <= {bor_q[4:3], r_bc[D], r_ac[D], r_ab[D]};
				end
			end
			ST_SUM: begin
				hl_q <= {{D{1'b0}}, hl_q[P-1:D]};
				pl_q <= {{D{1'b0}}, pl_q[P-1:D]};
				cy_q <= sum_t[D+1:D];
				if (step_last) begin
					// quotient stays below 2^P, so the top bits are the first remainder
					rem_q <= sum_nx[SUM_BITS-1:P];
					quo_q <= sum_nx[P-1:0];
				end
			end
			ST_DIV: begin
				rem_q <= qbit ? trial[LOG_W-1:0] : rem_sh[LOG_W-1:0];
				quo_q <= {quo_q[P-2:0], qbit};
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					result_q.range_average <= valid_q ? quo_q : '0;
					result_q.average_valid <= valid_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[sv/wtra_checker.sv]
// checker: port-level properties of the true range average unit, with its bind
module wtra_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              bar_valid,
	input logic              bar_ready,
	input logic              result_valid,
	input logic              result_ready,
	input wtra_pkg::result_t result
);

	import wtra_pkg::*;

	// a waiting result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while waiting");

	// no valid flag, no average
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.average_valid |-> result.range_average == '0)
		else $error("average nonzero without valid flag");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_ready |=> !bar_ready)
		else $error("ready stayed high after a request");

	// a new result comes with the block free again
	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> bar_ready)
		else $error("result appeared while busy");

endmodule

bind windowed_true_range_average_unit wtra_checker u_wtra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.bar_valid    (bar_valid),
	.bar_ready    (bar_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

[sim/tb.sv]
// testbench for the windowed true range average unit: directed and random bars against a predictor
`timescale 1ns / 100ps

module tb;
	import wtra_pkg::*;

	localparam int MAX_WINDOW  = 256;
	localparam int SUM_BITS    = PRICE_BITS + $clog2(MAX_WINDOW);
	localparam int STALL_LIMIT = 3000;

	typedef logic [SUM_BITS-1:0] sum_t;

	// block interface, every input known from time zero
	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    bar_valid    = 1'b0;
	logic    bar_ready;
	bar_t    bar          = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_we       = 1'b0;
	window_t cfg_wdata    = '0;

	// idling shares in percent of cycles, per side
	int bar_idle_pct   = 32;
	int ready_idle_pct = 73;

	// predictor copy of the block state
	window_t window_reg    = window_t'(RESET_WINDOW);
	price_t  last_close    = '0;
	price_t  tr_history [MAX_WINDOW];
	sum_t    tr_window_sum = '0;
	int      bar_count     = 0;
	int      hist_slot     = 0;

	// predicted results in request order
	result_t expected_averages [$];

	int bars_sent      = 0;
	int results_seen   = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	// price walk that shapes well-formed bars
	longint unsigned walk_price = 64'd1_000_000;

	windowed_true_range_average_unit #(
		.MAX_WINDOW(MAX_WINDOW)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.bar_valid   (bar_valid),
		.bar_ready   (bar_ready),
		.bar         (bar),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// true range of one bar, ring update and window average
	function automatic result_t predict_average(input bar_t b);
		result_t r;
		price_t  tr;
		price_t  gap_hi;
		price_t  gap_lo;
		int      w;
		int      slot;
		// zero acts as one, anything past the ring size as the ring size
		if (window_reg == 0) begin
			w = 1;
		end else if (window_reg > MAX_WINDOW) begin
			w = MAX_WINDOW;
		end else begin
			w = int'(window_reg);
		end
		// the first bar of a history only leaves its close behind
		if (bar_count > 0) begin
			tr = (b.bar_high >= b.bar_low) ? b.bar_high - b.bar_low : '0;
			gap_hi = (b.bar_high >= last_close) ? b.bar_high - last_close
			                                    : last_close - b.bar_high;
			gap_lo = (b.bar_low >= last_close) ? b.bar_low - last_close
			                                   : last_close - b.bar_low;
			if (gap_hi > tr) tr = gap_hi;
			if (gap_lo > tr) tr = gap_lo;
			slot = hist_slot % w;
			// oldest range drops out once the window is full
			if (bar_count - 1 >= w) tr_window_sum -= sum_t'(tr_history[slot]);
			tr_history[slot] = tr;
			tr_window_sum += sum_t'(tr);
			slot++;
			hist_slot = (slot >= w) ? 0 : slot;
		end
		if (bar_count < MAX_WINDOW + 1) bar_count++;
		last_close = b.bar_close;
		r.average_valid = (bar_count >= w + 1);
		r.range_average = r.average_valid ? price_t'(tr_window_sum / sum_t'(w)) : '0;
		return r;
	endfunction

	// mostly bars around a drifting price, some pure noise
	function automatic bar_t random_bar();
		bar_t            b;
		int unsigned     pick;
		int unsigned     span;
		int unsigned     d;
		longint unsigned lo;
		longint unsigned hi;
		pick = $urandom_range(99);
		if (pick < 12) begin
			// noise: any bits, high below low included
			b.bar_high  = $urandom;
			b.bar_low   = $urandom;
			b.bar_close = $urandom;
			return b;
		end
		// occasional jump of the walk to the price extremes or anywhere
		if (pick == 12) begin
			walk_price = 0;
		end else if (pick == 13) begin
			walk_price = 64'hFFFF_FFFF;
		end else if (pick == 14) begin
			walk_price = $urandom;
		end
		case ($urandom_range(3))
			0: begin
				span = $urandom_range(16);
			end
			1: begin
				span = $urandom_range(4096);
			end
			2: begin
				span = $urandom_range(32'h00FF_FFFF);
			end
			default: begin
				span = $urandom;
			end
		endcase
		// an opening gap so the distance to the last close can win
		if ($urandom_range(4) == 0) begin
			d = $urandom_range(span);
			if ($urandom_range(1) == 1) begin
				walk_price = (walk_price + d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : walk_price + d;
			end else begin
				walk_price = (walk_price >= d) ? walk_price - d : 0;
			end
		end
		d = $urandom_range(span);
		lo = (walk_price >= d) ? walk_price - d : 0;
		d = $urandom_range(span);
		hi = (walk_price + d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : walk_price + d;
		b.bar_low   = lo[31:0];
		b.bar_high  = hi[31:0];
		b.bar_close = $urandom_range(hi[31:0], lo[31:0]);
		walk_price  = b.bar_close;
		return b;
	endfunction

	// one request on the bar channel, with a random gap in front
	task automatic send_bar(input bar_t b);
		if ($urandom_range(99) < bar_idle_pct) begin
			bar_valid <= 1'b0;
			if ($urandom_range(3) == 0) begin
				// long gap so the pause lands on any phase of the block's work
				repeat ($urandom_range(64, 1)) @(posedge clk);
			end else begin
				do @(posedge clk); while ($urandom_range(99) < bar_idle_pct);
			end
		end
		bar       <= b;
		bar_valid <= 1'b1;
		do @(posedge clk); while (!bar_ready);
		expected_averages.push_back(predict_average(b));
		bars_sent++;
	endtask

	// sender holds off until every predicted result has come back
	task automatic wait_results_drained();
		bar_valid <= 1'b0;
		@(posedge clk);
		while (expected_averages.size() != 0) @(posedge clk);
	endtask

	// window write on an idle block; any write clears the history
	task automatic write_window(input window_t w);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_reg    = w;
		last_close    = '0;
		tr_window_sum = '0;
		bar_count     = 0;
		hist_slot     = 0;
	endtask

	// reset window length: full-scale swings fill the sum, then high below low
	task automatic test_reset_window();
		bar_t b;
		for (int i = 0; i < 16; i++) begin
			b.bar_high  = i[0] ? '1 : '0;
			b.bar_low   = i[0] ? '1 : '0;
			b.bar_close = i[0] ? '1 : '0;
			send_bar(b);
		end
		send_bar('{bar_high: 32'd100, bar_low: 32'd200, bar_close: 32'd150});
		send_bar('{bar_high: 32'd140, bar_low: 32'd160, bar_close: 32'd10});
	endtask

	// window extremes and each way the true range can be won
	task automatic test_special_bars();
		// zero acts as a one-bar window
		write_window('0);
		send_bar('{bar_high: 32'd1000, bar_low: 32'd900, bar_close: 32'd950});
		send_bar('{bar_high: 32'd1010, bar_low: 32'd990, bar_close: 32'd1000});
		send_bar('{bar_high: 32'd990, bar_low: 32'd1010, bar_close: 32'd995});
		send_bar('{bar_high: 32'd2000, bar_low: 32'd1900, bar_close: 32'd1950});
		send_bar('{bar_high: 32'd10, bar_low: 32'd5, bar_close: 32'd7});
		send_bar('{bar_high: 32'hAAAA_AAAA, bar_low: 32'h5555_5555, bar_close: 32'h5555_5555});
		send_bar('{bar_high: 32'h5555_5555, bar_low: 32'hAAAA_AAAA, bar_close: 32'hAAAA_AAAA});
		// shortest real window
		write_window(window_t'(1));
		send_bar('{bar_high: 32'hFFFF_FFFF, bar_low: 32'd0, bar_close: 32'd0});
		send_bar('{bar_high: 32'd0, bar_low: 32'hFFFF_FFFF, bar_close: 32'hFFFF_FFFF});
		// register maximum acts as the ring size, never valid this early
		write_window('1);
		send_bar('{bar_high: 32'd7, bar_low: 32'd3, bar_close: 32'd5});
		send_bar('{bar_high: 32'd9, bar_low: 32'd1, bar_close: 32'd2});
		send_bar('{bar_high: 32'd4, bar_low: 32'd4, bar_close: 32'd4});
	endtask

	// full ring: the window wraps at the ring size and past it
	task automatic test_long_window();
		write_window(window_t'(MAX_WINDOW));
		repeat (MAX_WINDOW + 44) send_bar(random_bar());
		write_window('1);
		repeat (MAX_WINDOW + 14) send_bar(random_bar());
	endtask

	// random windows, mostly small, each followed by a run of bars
	task automatic test_random_windows(input int sender_pct, input int receiver_pct,
	                                   input int bar_budget);
		int      stop_at;
		int      pick;
		int      eff;
		int      run_len;
		window_t w;
		bar_idle_pct   = sender_pct;
		ready_idle_pct = receiver_pct;
		stop_at        = bars_sent + bar_budget;
		while (bars_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				w = '0;
			end else if (pick < 40) begin
				w = window_t'($urandom_range(4, 1));
			end else if (pick < 75) begin
				w = window_t'($urandom_range(20, 5));
			end else if (pick < 93) begin
				w = window_t'($urandom_range(64, 21));
			end else begin
				w = window_t'($urandom_range(128, 65));
			end
			// now and then the history just carries on under the old window
			if ($urandom_range(9) != 0) write_window(w);
			eff = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW
			                                                         : int'(window_reg);
			// some runs stop before the average ever becomes valid
			if ($urandom_range(99) < 15) begin
				run_len = $urandom_range(eff, 1);
			end else begin
				run_len = eff + 1 + $urandom_range(2 * eff + 8);
			end
			repeat (run_len) begin
				if ($urandom_range(99) < 3) wait_results_drained();
				send_bar(random_bar());
			end
		end
	endtask

	// receiver stalls at random
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= ready_idle_pct);
	end

	// compare every result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_averages.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("result %0d with no bar waiting: average %0d valid %0b",
					         results_seen, result.range_average, result.average_valid);
				end
				mismatch_count++;
			end else begin
				want = expected_averages.pop_front();
				if (result.range_average !== want.range_average ||
				    result.average_valid !== want.average_valid) begin
					if (mismatch_count < 10) begin
						$display("result %0d: expected average %0d valid %0b, got %0d valid %0b",
						         results_seen, want.range_average, want.average_valid,
						         result.range_average, result.average_valid);
					end
					mismatch_count++;
				end
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (!arst_n || (bar_valid && bar_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// sender idles 32, receiver 73 for the directed part and the long window
		test_reset_window();
		test_special_bars();
		test_long_window();
		// roles swapped, then no idling at all
		test_random_windows(73, 32, 600);
		test_random_windows(0, 0, 600);
		wait_results_drained();
		// room for a stray result past the slowest bar
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && expected_averages.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
